### hdl/rtyc_pkg.sv
// rtyc_pkg: shared types and constants of the rgb to yuv 4:2:0 converter
// used by rtyc_cfg, rtyc_line_mem and rgb_to_yuv420_converter; no dependencies
package rtyc_pkg;

	localparam int MAX_HALF_WIDTH_DEF = 2048;
	localparam int HW_W = 12;
	localparam int PAIR_W = 14;
	localparam int QSUM_W = 7;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [HW_W-1:0] HALF_WIDTH_RST = 12'd320;

	// register index, taken from paddr[2]
	localparam logic REG_HALF_WIDTH = 1'b0;

	typedef struct packed {
		logic       frame_start;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pix_t;

	typedef struct packed {
		logic [7:0] luma;
		logic       chroma_valid;
		logic [7:0] chroma_blue;
		logic [7:0] chroma_red;
	} yuv_t;

endpackage

### hdl/rgb_to_yuv420_converter.sv
// rgb_to_yuv420_converter: bt.601 rgb pixel stream to y per pixel plus u,v per 2x2 block
// depends on rtyc_pkg, rtyc_cfg, rtyc_line_mem
//
// usage:
//   pixels enter on pix / pix_valid / pix_stall in raster order, frame_start set
//   on the first pixel of a frame. every pixel transfer gives one result transfer
//   on yuv / yuv_valid / yuv_stall carrying its luma; the right pixel of each pair
//   on an odd row also carries chroma_valid with the block's u and v.
//   half_width (image width / 2) is written over the apb port at byte address 0
//   while the stream is idle; it resets to 320.
//   a transferred pixel passes the pixel stage register and then the output register.
//   throughput: one pixel per cycle unless stalled; each pixel does at most one line
//   buffer access (read on odd rows, write on even rows) in the single-port-pair memory.
//   the even-row write of a column lands before the odd-row read of it is issued.
//   a stalled receiver holds the output register; the pixel stage behind it keeps
//   one more pixel, and pix_stall rises only when both are full.
//   reset clears counters, phase, held quarters and valids; the line buffer is not
//   cleared and needs none, since each even row writes before its odd row reads.
module rgb_to_yuv420_converter #(
	parameter int MAX_HALF_WIDTH = rtyc_pkg::MAX_HALF_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          pix_valid,
	output logic                          pix_stall,
	input  rtyc_pkg::pix_t                pix,
	output logic                          yuv_valid,
	input  logic                          yuv_stall,
	output rtyc_pkg::yuv_t                yuv,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [rtyc_pkg::PADDR_W-1:0]  paddr,
	input  logic [rtyc_pkg::PDATA_W-1:0]  pwdata,
	output logic [rtyc_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);
	import rtyc_pkg::*;

	localparam int IDX_W = (MAX_HALF_WIDTH > 1) ? $clog2(MAX_HALF_WIDTH) : 1;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_HALF_WIDTH - 1);

	logic [HW_W-1:0] half_width;

	// front control state
	logic [HW_W-1:0]  col_q;
	logic [IDX_W-1:0] idx_q;
	logic             odd_q;
	logic             second_q;

	logic [HW_W-1:0]  col_e, col_inc, col_n;
	logic [IDX_W-1:0] idx_e, idx_n;
	logic             odd_e, second_e, end_row;

	// pixel stage
	logic             v_s1;
	logic [7:0]       red_s1, green_s1, blue_s1;
	logic             second_s1, odd_s1;
	logic [IDX_W-1:0] idx_s1;

	logic [PAIR_W-1:0] held_q;
	logic [PAIR_W-1:0] line_rd;
	yuv_t              yuv_q;
	logic              yuv_valid_q;

	logic pix_acc, adv;

	logic [15:0] y_sum;
	logic [16:0] u_sum, v_sum;
	logic [5:0]  qu, qv;
	logic [QSUM_W-1:0] pu, pv;
	logic [7:0]  luma_c;
	logic        mem_we, mem_re;

	rtyc_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.half_width (half_width)
	);

	assign adv       = v_s1 & (~yuv_valid_q | ~yuv_stall);
	assign pix_stall = v_s1 & ~adv;
	assign pix_acc   = pix_valid & ~pix_stall;

	// counters as seen by the incoming pixel
	always_comb begin
		col_e    = pix.frame_start ? '0 : col_q;
		idx_e    = pix.frame_start ? '0 : idx_q;
		odd_e    = pix.frame_start ? 1'b0 : odd_q;
		second_e = pix.frame_start ? 1'b0 : second_q;
		col_inc  = col_e + HW_W'(1);
		end_row  = (col_inc == half_width);
		col_n    = end_row ? '0 : col_inc;
		if (col_n == '0 || idx_e == IDX_LAST) begin
			idx_n = '0;
		end else begin
			idx_n = idx_e + IDX_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			idx_q    <= '0;
			odd_q    <= 1'b0;
			second_q <= 1'b0;
		end else if (pix_acc) begin
			if (second_e) begin
				col_q    <= col_n;
				idx_q    <= idx_n;
				odd_q    <= odd_e ^ end_row;
				second_q <= 1'b0;
			end else begin
				col_q    <= col_e;
				idx_q    <= idx_e;
				odd_q    <= odd_e;
				second_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (pix_acc) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_acc) begin
			red_s1    <= pix.red;
			green_s1  <= pix.green;
			blue_s1   <= pix.blue;
			second_s1 <= second_e;
			odd_s1    <= odd_e;
			idx_s1    <= idx_e;
		end
	end

	assign mem_re = pix_acc & second_e & odd_e;
	assign mem_we = adv & second_s1 & ~odd_s1;

	rtyc_line_mem #(
		.DEPTH  (MAX_HALF_WIDTH),
		.ADDR_W (IDX_W)
	) u_line_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (idx_s1),
		.wdata ({pu, pv}),
		.re    (mem_re),
		.raddr (idx_e),
		.rdata (line_rd)
	);

	// color arithmetic; chroma sums carry the 128 rounding and +128 offset (32896)
	always_comb begin
		y_sum = 16'(17'(red_s1) * 17'd66 + 17'(green_s1) * 17'd129
			+ 17'(blue_s1) * 17'd25 + 17'd128);
		u_sum = 17'd32896 + 17'(blue_s1) * 17'd112
			- 17'(red_s1) * 17'd38 - 17'(green_s1) * 17'd74;
		v_sum = 17'd32896 + 17'(red_s1) * 17'd112
			- 17'(green_s1) * 17'd94 - 17'(blue_s1) * 17'd18;
		luma_c = y_sum[15:8] + 8'd16;
		qu     = u_sum[15:10];
		qv     = v_sum[15:10];
		pu     = held_q[PAIR_W-1:QSUM_W] + QSUM_W'(qu);
		pv     = held_q[QSUM_W-1:0] + QSUM_W'(qv);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (adv && !second_s1) begin
			held_q <= {QSUM_W'(qu), QSUM_W'(qv)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			yuv_valid_q <= 1'b0;
		end else if (adv) begin
			yuv_valid_q <= 1'b1;
		end else if (!yuv_stall) begin
			yuv_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			yuv_q.luma <= luma_c;
			if (second_s1 && odd_s1) begin
				yuv_q.chroma_valid <= 1'b1;
				yuv_q.chroma_blue  <= {1'b0, line_rd[PAIR_W-1:QSUM_W]} + {1'b0, pu};
				yuv_q.chroma_red   <= {1'b0, line_rd[QSUM_W-1:0]} + {1'b0, pv};
			end else begin
				yuv_q.chroma_valid <= 1'b0;
				yuv_q.chroma_blue  <= '0;
				yuv_q.chroma_red   <= '0;
			end
		end
	end

	assign yuv_valid = yuv_valid_q;
	assign yuv       = yuv_q;

	a_stall_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		pix_stall |-> (v_s1 && yuv_valid_q && yuv_stall))
		else $error("pixel stage stalled while not backed up");

	a_write_even_pair: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (v_s1 && second_s1 && !odd_s1))
		else $error("line buffer written outside an even-row pair end");

	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_acc && pix.frame_start) |=> (!second_s1 && !odd_s1 && idx_s1 == '0))
		else $error("frame start did not restart the counters");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= IDX_LAST)
		else $error("line buffer index beyond depth");

endmodule

### hdl/rtyc_cfg.sv
// rtyc_cfg: apb-style register port holding half_width
// depends on rtyc_pkg
module rtyc_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [rtyc_pkg::PADDR_W-1:0]  paddr,
	input  logic [rtyc_pkg::PDATA_W-1:0]  pwdata,
	output logic [rtyc_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	output logic [rtyc_pkg::HW_W-1:0]     half_width
);
	import rtyc_pkg::*;

	logic [HW_W-1:0] half_width_q;
	logic            wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_width_q <= HALF_WIDTH_RST;
		end else if (wr_en && paddr[2] == REG_HALF_WIDTH) begin
			half_width_q <= pwdata[HW_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_HALF_WIDTH) begin
			prdata = {{(PDATA_W-HW_W){1'b0}}, half_width_q};
		end
	end

	assign half_width = half_width_q;

endmodule

### hdl/rtyc_line_mem.sv
// rtyc_line_mem: line buffer of even-row chroma pair sums, one write and one read port
// registered read data; depends on rtyc_pkg
module rtyc_line_mem #(
	parameter int DEPTH  = rtyc_pkg::MAX_HALF_WIDTH_DEF,
	parameter int ADDR_W = 11
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [ADDR_W-1:0]           waddr,
	input  logic [rtyc_pkg::PAIR_W-1:0] wdata,
	input  logic                        re,
	input  logic [ADDR_W-1:0]           raddr,
	output logic [rtyc_pkg::PAIR_W-1:0] rdata
);
	import rtyc_pkg::*;

	logic [PAIR_W-1:0] mem [DEPTH];
	logic [PAIR_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### verif/rgb_to_yuv420_converter_test.sv
// rgb_to_yuv420_converter_test: self-checking bench for the rgb to yuv 4:2:0 converter
// predicts luma and 2x2 block chroma per pixel transfer and checks every result transfer
// depends on rtyc_pkg and rgb_to_yuv420_converter
`timescale 1ns / 1ps

module rgb_to_yuv420_converter_test;
	import rtyc_pkg::*;

	class yuv420_scoreboard;
		logic [PAIR_W-1:0] pair_sums [MAX_HALF_WIDTH_DEF];
		logic [HW_W-1:0]   half_width;
		logic [HW_W-1:0]   col;
		logic [PAIR_W-1:0] held;
		bit                odd_row;
		bit                right_pixel;
		yuv_t              yuv_due [$];
		int                errors;
		int                pixels;
		int                checked;
		int                blocks;

		function new();
			half_width = HALF_WIDTH_RST;
			col = '0;
			held = '0;
			foreach (pair_sums[i]) pair_sums[i] = '0;
		endfunction

		function int pending();
			return yuv_due.size();
		endfunction

		function int chroma_quarter(int s);
			return ((s >>> 8) + 128) / 4;
		endfunction

		function void predict_yuv(pix_t p);
			int r, g, b, qu, qv, pu, pv, idx;
			yuv_t e;
			r = p.red;
			g = p.green;
			b = p.blue;
			e = '0;
			pixels++;
			if (p.frame_start) begin
				col = '0;
				odd_row = 0;
				right_pixel = 0;
			end
			e.luma = 8'(((66 * r + 129 * g + 25 * b + 128) >>> 8) + 16);
			qu = chroma_quarter(-38 * r - 74 * g + 112 * b + 128);
			qv = chroma_quarter(112 * r - 94 * g - 18 * b + 128);
			if (!right_pixel) begin
				held = {QSUM_W'(qu), QSUM_W'(qv)};
				right_pixel = 1;
			end else begin
				pu = held[PAIR_W-1:QSUM_W] + qu;
				pv = held[QSUM_W-1:0] + qv;
				idx = col % MAX_HALF_WIDTH_DEF;
				if (!odd_row) begin
					pair_sums[idx] = {QSUM_W'(pu), QSUM_W'(pv)};
				end else begin
					e.chroma_valid = 1'b1;
					e.chroma_blue = 8'(pair_sums[idx][PAIR_W-1:QSUM_W] + pu);
					e.chroma_red = 8'(pair_sums[idx][QSUM_W-1:0] + pv);
				end
				right_pixel = 0;
				if (HW_W'(col + 1) == half_width) begin
					col = '0;
					odd_row = !odd_row;
				end else begin
					col = HW_W'(col + 1);
				end
			end
			yuv_due.push_back(e);
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 20)
				$display("mismatch: %s", msg);
		endtask

		task check_yuv(yuv_t got);
			yuv_t e;
			if (yuv_due.size() == 0) begin
				report($sformatf("result with none expected: y=%0d cv=%b u=%0d v=%0d",
					got.luma, got.chroma_valid, got.chroma_blue, got.chroma_red));
				return;
			end
			e = yuv_due.pop_front();
			checked++;
			if (e.chroma_valid)
				blocks++;
			if (got.luma !== e.luma || got.chroma_valid !== e.chroma_valid ||
					got.chroma_blue !== e.chroma_blue || got.chroma_red !== e.chroma_red)
				report($sformatf("result %0d: got y=%0d cv=%b u=%0d v=%0d, want y=%0d cv=%b u=%0d v=%0d",
					checked, got.luma, got.chroma_valid, got.chroma_blue, got.chroma_red,
					e.luma, e.chroma_valid, e.chroma_blue, e.chroma_red));
		endtask
	endclass

	logic               clk;
	logic               arst_n;
	logic               pix_valid;
	logic               pix_stall;
	pix_t               pix;
	logic               yuv_valid;
	logic               yuv_stall;
	yuv_t               yuv;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	yuv420_scoreboard sb;
	bit idling;
	int stall_left;
	int settings;

	rgb_to_yuv420_converter dut (
		.clk(clk),
		.arst_n(arst_n),
		.pix_valid(pix_valid),
		.pix_stall(pix_stall),
		.pix(pix),
		.yuv_valid(yuv_valid),
		.yuv_stall(yuv_stall),
		.yuv(yuv),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (stall_left > 0)
			stall_left--;
		else if (idling && $urandom_range(5) == 0)
			stall_left = $urandom_range(1, 6);
		yuv_stall <= (stall_left > 0);
	end

	always @(posedge clk) begin
		if (arst_n && yuv_valid && !yuv_stall)
			sb.check_yuv(yuv);
	end

	function automatic logic [23:0] corner(int k);
		return {{8{k[2]}}, {8{k[1]}}, {8{k[0]}}};
	endfunction

	function automatic logic [23:0] rand_rgb();
		if ($urandom_range(7) == 0)
			return corner($urandom_range(7));
		return 24'($urandom);
	endfunction

	task automatic send_pixel(bit fs, logic [23:0] rgb);
		pix_t p;
		p = {fs, rgb};
		if (idling && $urandom_range(3) == 0) begin
			pix_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		pix_valid <= 1'b1;
		pix <= p;
		do @(posedge clk); while (pix_stall);
		sb.predict_yuv(p);
	endtask

	// frames of random height, optionally cut short by a stray frame_start
	task automatic run_stream(int total, bit fresh, bit noisy);
		int frame_left, width;
		bit fs;
		width = (sb.half_width == 0) ? 8192 : 2 * sb.half_width;
		frame_left = fresh ? 0 : total;
		for (int i = 0; i < total; i++) begin
			fs = (frame_left <= 0) || (noisy && $urandom_range(149) == 0);
			if (fs)
				frame_left = width * $urandom_range(1, 6);
			send_pixel(fs, rand_rgb());
			frame_left--;
		end
	endtask

	task automatic apb_read(output logic [PDATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {REG_HALF_WIDTH, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		data = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic write_half_width(logic [HW_W-1:0] v);
		logic [PDATA_W-1:0] rd;
		pix_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_HALF_WIDTH, 2'b00};
		pwdata <= {(PDATA_W-HW_W)'($urandom), v};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		sb.half_width = v;
		settings++;
		@(posedge clk);
		apb_read(rd);
		if (rd[HW_W-1:0] !== v)
			sb.report($sformatf("half_width reads %0d after writing %0d", rd[HW_W-1:0], v));
	endtask

	initial begin
		logic [PDATA_W-1:0] rd;
		sb = new();
		clk = 1'b0;
		arst_n = 1'b0;
		pix_valid = 1'b0;
		pix = '0;
		yuv_stall = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		idling = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		apb_read(rd);
		if (rd[HW_W-1:0] !== sb.half_width)
			sb.report($sformatf("half_width reads %0d after reset", rd[HW_W-1:0]));

		// rgb cube corners over a 4 pixel wide image, then a short frame and a cut frame
		idling = 1;
		write_half_width(12'd2);
		for (int k = 0; k < 8; k++)
			send_pixel(k == 0, corner(k));
		for (int k = 0; k < 6; k++)
			send_pixel(k == 0, corner(7 - k));
		run_stream(2, 1, 0);
		run_stream(8, 1, 0);

		for (int ph = 0; ph < 6; ph++) begin
			idling = $urandom_range(3) != 0;
			write_half_width(ph == 0 ? 12'd1 : HW_W'($urandom_range(1, 24)));
			run_stream(80, 1, 1);
		end

		// start of a row at the widest image, zero width and width past the line buffer
		idling = 1;
		write_half_width(12'd2048);
		run_stream(80, 1, 0);
		write_half_width(12'd0);
		run_stream(40, 1, 0);
		write_half_width(12'd4095);
		run_stream(40, 1, 0);

		// shrink the width mid even row so the row ends at the next pair
		write_half_width(12'd8);
		run_stream(12, 1, 0);
		write_half_width(12'd7);
		run_stream(40, 0, 0);

		idling = 0;
		write_half_width(HW_W'($urandom_range(1, 12)));
		run_stream(60, 1, 1);
		pix_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("%0d pixel transfers over %0d width settings, incl. zero, 2048 and 4095",
			sb.pixels, settings);
		$display("%0d results checked, %0d carrying block chroma, %0d mismatches",
			sb.checked, sb.blocks, sb.errors);
		if (sb.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("timeout");
		$display("*** FAILED ***");
		$finish;
	end

endmodule

### sim.f
hdl/rtyc_pkg.sv
hdl/rtyc_cfg.sv
hdl/rtyc_line_mem.sv
hdl/rgb_to_yuv420_converter.sv
verif/rgb_to_yuv420_converter_test.sv
